>>> rtl/core/efc_pkg.sv
// ----------------------------------------------------------------------------
// efc_pkg: shared types and constants for the fraction comparator
// Field width, order codes, sequencer states and the control and status
// bundles passed between the serial dividers, the quotient comparator
// and the top-level sequencer.
// ----------------------------------------------------------------------------
package efc_pkg;

	localparam int unsigned W     = 64;
	localparam int unsigned CNT_W = $clog2(W);

	typedef logic [W-1:0]     word_t;
	typedef logic [CNT_W-1:0] cnt_t;

	localparam cnt_t CNT_LAST = cnt_t'(W - 1);

	typedef logic [1:0] order_t;
	localparam order_t ORD_LESS    = 2'd0;
	localparam order_t ORD_EQUAL   = 2'd1;
	localparam order_t ORD_GREATER = 2'd2;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_RUN,
		ST_CHECK
	} state_t;

	// load: take a new dividend/divisor pair; step: one quotient bit
	typedef struct packed {
		logic load;
		logic step;
	} div_ctl_t;

	// diff: quotients differ in some bit seen so far; less: left < right
	typedef struct packed {
		logic diff;
		logic less;
	} qcmp_stat_t;

endpackage

>>> rtl/core/efc_div.sv
// ----------------------------------------------------------------------------
// efc_div: bit-serial restoring divider
// Shifts the dividend out one bit per cycle while step is high, into a
// partial remainder, giving one quotient bit per step, most significant first.
// ----------------------------------------------------------------------------
module efc_div (
	input  logic              clk,
	input  efc_pkg::div_ctl_t ctl,
	input  efc_pkg::word_t    dividend,
	input  efc_pkg::word_t    divisor,
	output logic              qbit,
	output efc_pkg::word_t    rem,
	output efc_pkg::word_t    dsr
);

	efc_pkg::word_t       dvd_q;
	efc_pkg::word_t       rem_q;
	efc_pkg::word_t       dsr_q;
	logic [efc_pkg::W:0]  shifted;
	logic [efc_pkg::W:0]  trial;

	always_comb begin
		shifted = {rem_q, dvd_q[efc_pkg::W-1]};
		trial   = shifted - {1'b0, dsr_q};
		qbit    = ~trial[efc_pkg::W];
	end

	// subtract only when the shifted remainder covers the divisor
	always_ff @(posedge clk) begin
		if (ctl.load) begin
			dvd_q <= dividend;
			rem_q <= '0;
			dsr_q <= divisor;
		end else if (ctl.step) begin
			dvd_q <= {dvd_q[efc_pkg::W-2:0], 1'b0};
			rem_q <= qbit ? trial[efc_pkg::W-1:0] : shifted[efc_pkg::W-1:0];
		end
	end

	assign rem = rem_q;
	assign dsr = dsr_q;

endmodule

>>> rtl/core/efc_qcmp.sv
// ----------------------------------------------------------------------------
// efc_qcmp: serial quotient comparator
// Watches both quotient bit streams, most significant first, and latches
// the order at the first position where they differ.
// ----------------------------------------------------------------------------
module efc_qcmp (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                clear,
	input  logic                step,
	input  logic                lbit,
	input  logic                rbit,
	output efc_pkg::qcmp_stat_t stat
);

	logic diff_q;
	logic less_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			diff_q <= 1'b0;
			less_q <= 1'b0;
		end else if (clear) begin
			diff_q <= 1'b0;
			less_q <= 1'b0;
		end else if (step && !diff_q && (lbit != rbit)) begin
			diff_q <= 1'b1;
			less_q <= rbit;
		end
	end

	assign stat.diff = diff_q;
	assign stat.less = less_q;

endmodule

>>> rtl/core/exact_fraction_compare_top.sv
// ----------------------------------------------------------------------------
// exact_fraction_compare_top: exact order of two unsigned 64-bit fractions
// Expands both fractions together as continued fractions with two
// bit-serial dividers and compares the quotients term by term.
// ----------------------------------------------------------------------------
// Usage: pulse start while busy is low to transfer left_num/left_den and
// right_num/right_den. The answer appears on order and bad_input, marked by
// done, high for exactly one cycle; order and bad_input keep it until the
// next accepted start, but capture it in that cycle. Each continued-fraction
// term takes W = 64 quotient bits from the two serial dividers running in
// lockstep, then an inspection of the quotients and remainders; a comparison
// has up to about 93 terms for 64-bit operands. A zero denominator skips the
// division entirely: done rises in the cycle after start, with bad_input set
// and order reading equal. busy drops in the cycle that done rises, so the
// next item may be transferred while a result shows.
// ----------------------------------------------------------------------------
module exact_fraction_compare_top (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   start,
	output logic                   busy,
	input  logic [63:0]            left_num,
	input  logic [63:0]            left_den,
	input  logic [63:0]            right_num,
	input  logic [63:0]            right_den,
	output logic                   done,
	output logic [1:0]             order,
	output logic                   bad_input
);

	efc_pkg::state_t     state_q, state_nxt;
	efc_pkg::cnt_t       cnt_q;
	logic                flip_q;
	logic                done_q;
	efc_pkg::order_t     order_q;
	logic                bad_q;

	efc_pkg::div_ctl_t   dctl;
	logic                qclear;
	logic                accept;
	logic                den_zero;

	efc_pkg::word_t      l_dvd, l_dsr, r_dvd, r_dsr;
	logic                l_qbit, r_qbit;
	efc_pkg::word_t      l_rem, r_rem, l_div, r_div;
	efc_pkg::qcmp_stat_t qstat;

	logic                l_rz, r_rz;
	logic                decided;
	efc_pkg::order_t     raw_order;
	efc_pkg::order_t     fin_order;

	assign accept   = start && (state_q == efc_pkg::ST_IDLE);
	assign den_zero = (left_den == '0) || (right_den == '0);

	// term inspection: quotients first, then a zero remainder
	always_comb begin
		l_rz      = (l_rem == '0);
		r_rz      = (r_rem == '0);
		decided   = qstat.diff || l_rz || r_rz;
		raw_order = efc_pkg::ORD_EQUAL;
		if (qstat.diff) begin
			raw_order = qstat.less ? efc_pkg::ORD_LESS : efc_pkg::ORD_GREATER;
		end else if (l_rz && r_rz) begin
			raw_order = efc_pkg::ORD_EQUAL;
		end else if (l_rz) begin
			raw_order = efc_pkg::ORD_LESS;
		end else if (r_rz) begin
			raw_order = efc_pkg::ORD_GREATER;
		end
		// odd terms compare reciprocals, so flip the sense
		fin_order = raw_order;
		if (flip_q && raw_order == efc_pkg::ORD_LESS) begin
			fin_order = efc_pkg::ORD_GREATER;
		end else if (flip_q && raw_order == efc_pkg::ORD_GREATER) begin
			fin_order = efc_pkg::ORD_LESS;
		end
	end

	// next state
	always_comb begin
		state_nxt = state_q;
		case (state_q)
			efc_pkg::ST_IDLE: begin
				if (accept && !den_zero) begin
					state_nxt = efc_pkg::ST_RUN;
				end
			end
			efc_pkg::ST_RUN: begin
				if (cnt_q == efc_pkg::CNT_LAST) begin
					state_nxt = efc_pkg::ST_CHECK;
				end
			end
			efc_pkg::ST_CHECK: begin
				state_nxt = decided ? efc_pkg::ST_IDLE : efc_pkg::ST_RUN;
			end
			default: begin
				state_nxt = efc_pkg::ST_IDLE;
			end
		endcase
	end

	// outputs to the datapath
	always_comb begin
		dctl.load = 1'b0;
		dctl.step = 1'b0;
		qclear    = 1'b0;
		l_dvd     = left_num;
		l_dsr     = left_den;
		r_dvd     = right_num;
		r_dsr     = right_den;
		busy      = 1'b1;
		case (state_q)
			efc_pkg::ST_IDLE: begin
				busy      = 1'b0;
				dctl.load = accept;
				qclear    = accept;
			end
			efc_pkg::ST_RUN: begin
				dctl.step = 1'b1;
			end
			efc_pkg::ST_CHECK: begin
				// next term: old divisor over old remainder
				dctl.load = !decided;
				qclear    = !decided;
				l_dvd     = l_div;
				l_dsr     = l_rem;
				r_dvd     = r_div;
				r_dsr     = r_rem;
			end
			default: begin
				busy = 1'b1;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= efc_pkg::ST_IDLE;
			cnt_q   <= '0;
			flip_q  <= 1'b0;
			done_q  <= 1'b0;
		end else begin
			state_q <= state_nxt;
			if (dctl.load) begin
				cnt_q <= '0;
			end else if (dctl.step) begin
				cnt_q <= cnt_q + 1'b1;
			end
			if (accept) begin
				flip_q <= 1'b0;
				done_q <= den_zero;
			end else if (state_q == efc_pkg::ST_CHECK) begin
				flip_q <= ~flip_q;
				done_q <= decided;
			end else begin
				done_q <= 1'b0;
			end
		end
	end

	// result payload: hold between strobes
	always_ff @(posedge clk) begin
		if (accept) begin
			order_q <= efc_pkg::ORD_EQUAL;
			bad_q   <= den_zero;
		end else if (state_q == efc_pkg::ST_CHECK && decided) begin
			order_q <= fin_order;
			bad_q   <= 1'b0;
		end
	end

	efc_div u_div_l (
		.clk      (clk),
		.ctl      (dctl),
		.dividend (l_dvd),
		.divisor  (l_dsr),
		.qbit     (l_qbit),
		.rem      (l_rem),
		.dsr      (l_div)
	);

	efc_div u_div_r (
		.clk      (clk),
		.ctl      (dctl),
		.dividend (r_dvd),
		.divisor  (r_dsr),
		.qbit     (r_qbit),
		.rem      (r_rem),
		.dsr      (r_div)
	);

	efc_qcmp u_qcmp (
		.clk    (clk),
		.arst_n (arst_n),
		.clear  (qclear),
		.step   (dctl.step),
		.lbit   (l_qbit),
		.rbit   (r_qbit),
		.stat   (qstat)
	);

	assign done      = done_q;
	assign order     = order_q;
	assign bad_input = bad_q;

endmodule
